### src/dwec_pkg.sv
// Package for the dual wheel encoder edge counter.
// Holds the counter width, request, mode and register codes, and the edge rule.
// No dependencies.
package dwec_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int OUT_WIDTH   = 16;

    typedef logic [1:0]             t_req;
    typedef logic [1:0]             t_mode;
    typedef logic [3:0]             t_pins;
    typedef logic [COUNT_WIDTH-1:0] t_count;

    localparam t_req REQ_SAMPLE     = 2'd0;
    localparam t_req REQ_READ_RIGHT = 2'd1;
    localparam t_req REQ_READ_LEFT  = 2'd2;

    localparam t_mode MODE_A_RISE    = 2'd0;
    localparam t_mode MODE_A_BOTH    = 2'd1;
    localparam t_mode MODE_AB_RISE   = 2'd2;
    localparam t_mode MODE_AB_BOTH   = 2'd3;

    localparam logic CFG_MODE_RIGHT = 1'b0;
    localparam logic CFG_MODE_LEFT  = 1'b1;

    localparam int PIN_RA = 0;
    localparam int PIN_RB = 1;
    localparam int PIN_LA = 2;
    localparam int PIN_LB = 3;

    localparam logic WHEEL_RIGHT = 1'b0;
    localparam logic WHEEL_LEFT  = 1'b1;

    // Number of counted edges for one wheel; bit 0 is A, bit 1 is B.
    function automatic logic [1:0] edge_hits(input t_mode mode, input logic [1:0] old_ab,
                                             input logic [1:0] new_ab);
        logic a_fall_en;
        logic b_rise_en;
        logic b_fall_en;
        logic [1:0] hits;
        a_fall_en = (mode == MODE_A_BOTH) || (mode == MODE_AB_BOTH);
        b_rise_en = (mode == MODE_AB_RISE) || (mode == MODE_AB_BOTH);
        b_fall_en = (mode == MODE_AB_BOTH);
        hits = 2'd0;
        hits = hits + {1'b0, !old_ab[0] && new_ab[0]};
        hits = hits + {1'b0, old_ab[0] && !new_ab[0] && a_fall_en};
        hits = hits + {1'b0, !old_ab[1] && new_ab[1] && b_rise_en};
        hits = hits + {1'b0, old_ab[1] && !new_ab[1] && b_fall_en};
        return hits;
    endfunction

endpackage

### src/dual_wheel_encoder_edge_counter.sv
// Dual wheel encoder edge counter: input register, edge logic, result register.
// Depends on dwec_pkg.
// Latency: a read item's result passes through the input register and then the result register,
// and waits in the input register while the result register holds an earlier result not yet taken.
// Throughput: one item per cycle, set by the single pass through the edge logic, except while a read waits there.
// Reset: synchronous, active low; clears counts, stored levels, pending clears and modes.
module dual_wheel_encoder_edge_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_pin_levels,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_wheel_count,
    output logic        o_which_wheel,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [1:0]  i_cfg_data
);

    localparam int CW = dwec_pkg::COUNT_WIDTH;

    logic                  r_in_valid;
    dwec_pkg::t_req        r_req;
    dwec_pkg::t_pins       r_pins;

    dwec_pkg::t_mode       r_mode_right;
    dwec_pkg::t_mode       r_mode_left;
    dwec_pkg::t_pins       r_last;
    dwec_pkg::t_count      r_count_right;
    dwec_pkg::t_count      r_count_left;
    logic                  r_clr_right;
    logic                  r_clr_left;

    logic                  r_out_valid;
    logic [15:0]           r_wheel_count;
    logic                  r_which_wheel;

    logic                  is_read_right;
    logic                  is_read_left;
    logic                  is_sample;
    logic                  out_free;
    logic                  advance;
    logic                  do_sample;
    logic [1:0]            hits_right;
    logic [1:0]            hits_left;
    dwec_pkg::t_count      base_right;
    dwec_pkg::t_count      base_left;
    dwec_pkg::t_count      n_count_right;
    dwec_pkg::t_count      n_count_left;
    logic [CW+15:0]        ext_right;
    logic [CW+15:0]        ext_left;

    assign is_read_right = (r_req == dwec_pkg::REQ_READ_RIGHT);
    assign is_read_left  = (r_req == dwec_pkg::REQ_READ_LEFT);
    assign is_sample     = (r_req == dwec_pkg::REQ_SAMPLE);
    assign out_free      = !r_out_valid || i_out_ready;
    assign advance       = r_in_valid && (out_free || !(is_read_right || is_read_left));
    assign o_in_ready    = !r_in_valid || advance;
    assign do_sample     = advance && is_sample && (r_pins != r_last);

    assign hits_right = dwec_pkg::edge_hits(r_mode_right,
        {r_last[dwec_pkg::PIN_RB], r_last[dwec_pkg::PIN_RA]},
        {r_pins[dwec_pkg::PIN_RB], r_pins[dwec_pkg::PIN_RA]});
    assign hits_left = dwec_pkg::edge_hits(r_mode_left,
        {r_last[dwec_pkg::PIN_LB], r_last[dwec_pkg::PIN_LA]},
        {r_pins[dwec_pkg::PIN_LB], r_pins[dwec_pkg::PIN_LA]});

    assign base_right    = r_clr_right ? '0 : r_count_right;
    assign base_left     = r_clr_left  ? '0 : r_count_left;
    assign n_count_right = base_right + {{(CW-2){1'b0}}, hits_right};
    assign n_count_left  = base_left  + {{(CW-2){1'b0}}, hits_left};

    assign ext_right = {16'd0, r_count_right};
    assign ext_left  = {16'd0, r_count_left};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_mode_right  <= dwec_pkg::MODE_A_RISE;
            r_mode_left   <= dwec_pkg::MODE_A_RISE;
            r_last        <= '0;
            r_count_right <= '0;
            r_count_left  <= '0;
            r_clr_right   <= 1'b0;
            r_clr_left    <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dwec_pkg::CFG_MODE_RIGHT: r_mode_right <= i_cfg_data;
                    dwec_pkg::CFG_MODE_LEFT:  r_mode_left  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (do_sample) begin
                r_last        <= r_pins;
                r_count_right <= n_count_right;
                r_count_left  <= n_count_left;
                r_clr_right   <= 1'b0;
                r_clr_left    <= 1'b0;
            end else if (advance && is_read_right) begin
                r_clr_right <= 1'b1;
            end else if (advance && is_read_left) begin
                r_clr_left <= 1'b1;
            end
            if (advance && (is_read_right || is_read_left)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req  <= i_req_type;
            r_pins <= i_pin_levels;
        end
        if (advance && is_read_right) begin
            r_wheel_count <= ext_right[15:0];
            r_which_wheel <= dwec_pkg::WHEEL_RIGHT;
        end else if (advance && is_read_left) begin
            r_wheel_count <= ext_left[15:0];
            r_which_wheel <= dwec_pkg::WHEEL_LEFT;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_wheel_count = r_wheel_count;
    assign o_which_wheel = r_which_wheel;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench for the dual wheel encoder edge counter: directed and random pin samples and
// count reads under every edge mode and several handshake idling patterns, scoreboard checked.
// Depends on dwec_pkg and dual_wheel_encoder_edge_counter.
module testbench;

    localparam dwec_pkg::t_req REQ_UNUSED     = 2'd3;
    localparam int             WATCHDOG_LIMIT = 2000;
    localparam int             PHASE_ITEMS    = 325;

    typedef struct packed {
        logic [dwec_pkg::OUT_WIDTH-1:0] count;
        logic                           wheel;
    } t_wheel_read;

    class wheel_count_scoreboard;
        dwec_pkg::t_mode   mode_right;
        dwec_pkg::t_mode   mode_left;
        dwec_pkg::t_pins   last_pins;
        dwec_pkg::t_count  count_right;
        dwec_pkg::t_count  count_left;
        bit                clear_right;
        bit                clear_left;
        t_wheel_read       expected_reads[$];
        int                n_samples;
        int                n_reads;
        int                n_mismatches;

        function new();
            mode_right   = dwec_pkg::MODE_A_RISE;
            mode_left    = dwec_pkg::MODE_A_RISE;
            last_pins    = '0;
            count_right  = '0;
            count_left   = '0;
            clear_right  = 1'b0;
            clear_left   = 1'b0;
            n_samples    = 0;
            n_reads      = 0;
            n_mismatches = 0;
        endfunction

        function void write_mode(logic index, dwec_pkg::t_mode value);
            if (index == dwec_pkg::CFG_MODE_RIGHT) begin
                mode_right = value;
            end else begin
                mode_left = value;
            end
        endfunction

        function logic [1:0] wheel_edges(dwec_pkg::t_mode m, logic [1:0] was,
                                         logic [1:0] now);
            logic [1:0] n;
            n = 2'd0;
            if (!was[0] && now[0]) begin
                n++;
            end
            if (was[0] && !now[0] &&
                (m == dwec_pkg::MODE_A_BOTH || m == dwec_pkg::MODE_AB_BOTH)) begin
                n++;
            end
            if (!was[1] && now[1] &&
                (m == dwec_pkg::MODE_AB_RISE || m == dwec_pkg::MODE_AB_BOTH)) begin
                n++;
            end
            if (was[1] && !now[1] && m == dwec_pkg::MODE_AB_BOTH) begin
                n++;
            end
            return n;
        endfunction

        function void note_item(dwec_pkg::t_req req, dwec_pkg::t_pins pins);
            t_wheel_read rd;
            case (req)
                dwec_pkg::REQ_SAMPLE: begin
                    n_samples++;
                    if (pins != last_pins) begin
                        if (clear_left) begin
                            count_left = '0;
                            clear_left = 1'b0;
                        end
                        if (clear_right) begin
                            count_right = '0;
                            clear_right = 1'b0;
                        end
                        count_right = count_right + wheel_edges(mode_right,
                            {last_pins[dwec_pkg::PIN_RB], last_pins[dwec_pkg::PIN_RA]},
                            {pins[dwec_pkg::PIN_RB], pins[dwec_pkg::PIN_RA]});
                        count_left = count_left + wheel_edges(mode_left,
                            {last_pins[dwec_pkg::PIN_LB], last_pins[dwec_pkg::PIN_LA]},
                            {pins[dwec_pkg::PIN_LB], pins[dwec_pkg::PIN_LA]});
                        last_pins = pins;
                    end
                end
                dwec_pkg::REQ_READ_RIGHT: begin
                    rd.count = count_right[dwec_pkg::OUT_WIDTH-1:0];
                    rd.wheel = dwec_pkg::WHEEL_RIGHT;
                    expected_reads.push_back(rd);
                    clear_right = 1'b1;
                end
                dwec_pkg::REQ_READ_LEFT: begin
                    rd.count = count_left[dwec_pkg::OUT_WIDTH-1:0];
                    rd.wheel = dwec_pkg::WHEEL_LEFT;
                    expected_reads.push_back(rd);
                    clear_left = 1'b1;
                end
                default: begin
                end
            endcase
        endfunction

        function void flag(string msg);
            n_mismatches++;
            if (n_mismatches <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void check_read(logic [dwec_pkg::OUT_WIDTH-1:0] count, logic wheel);
            t_wheel_read want;
            if (expected_reads.size() == 0) begin
                flag($sformatf("Unexpected read result: count %0d wheel %0d", count, wheel));
                return;
            end
            want = expected_reads.pop_front();
            n_reads++;
            if (count !== want.count || wheel !== want.wheel) begin
                flag($sformatf({"Read mismatch: expected count %0d wheel %0d, ",
                                "got count %0d wheel %0d"},
                               want.count, want.wheel, count, wheel));
            end
        endfunction

        function int pending();
            return expected_reads.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_req_type    = dwec_pkg::REQ_SAMPLE;
    logic [3:0]           i_pin_levels  = '0;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    logic [15:0]          o_wheel_count;
    logic                 o_which_wheel;
    logic                 i_cfg_we      = 1'b0;
    logic                 i_cfg_index   = dwec_pkg::CFG_MODE_RIGHT;
    logic [1:0]           i_cfg_data    = dwec_pkg::MODE_A_RISE;

    wheel_count_scoreboard sb = new();

    int              sender_idle_pct = 0;
    int              recv_stall_pct  = 0;
    int              quiet_cycles    = 0;
    int              n_items         = 0;
    int              n_settings      = 0;
    dwec_pkg::t_pins sent_pins       = '0;

    dwec_pkg::t_mode right_modes[6] = '{dwec_pkg::MODE_A_RISE, dwec_pkg::MODE_AB_BOTH,
                                        dwec_pkg::MODE_A_BOTH, dwec_pkg::MODE_AB_RISE,
                                        dwec_pkg::MODE_AB_BOTH, dwec_pkg::MODE_A_RISE};
    dwec_pkg::t_mode left_modes[6]  = '{dwec_pkg::MODE_AB_BOTH, dwec_pkg::MODE_A_RISE,
                                        dwec_pkg::MODE_AB_RISE, dwec_pkg::MODE_A_BOTH,
                                        dwec_pkg::MODE_AB_BOTH, dwec_pkg::MODE_A_RISE};
    int              send_idle[6]   = '{0, 67, 0, 6, 67, 0};
    int              recv_stall[6]  = '{0, 0, 67, 6, 0, 67};

    dual_wheel_encoder_edge_counter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_pin_levels  (i_pin_levels),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_wheel_count (o_wheel_count),
        .o_which_wheel (o_which_wheel),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                sb.write_mode(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_item(i_req_type, i_pin_levels);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_read(o_wheel_count, o_which_wheel);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(input dwec_pkg::t_req req, input dwec_pkg::t_pins pins);
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_pin_levels <= pins;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        if (req == dwec_pkg::REQ_SAMPLE) begin
            sent_pins = pins;
        end
        if (req != REQ_UNUSED) begin
            n_items++;
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_modes(input dwec_pkg::t_mode right, input dwec_pkg::t_mode left);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= dwec_pkg::CFG_MODE_RIGHT;
        i_cfg_data  <= right;
        @(posedge i_clk);
        i_cfg_index <= dwec_pkg::CFG_MODE_LEFT;
        i_cfg_data  <= left;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_settings++;
    endtask

    // Mostly quadrature steps (at most one channel per wheel toggles), plus noise, repeats, unused requests and reads.
    task automatic next_random(output dwec_pkg::t_req req, output dwec_pkg::t_pins pins);
        int              pick;
        dwec_pkg::t_pins flip;
        pick = $urandom_range(0, 99);
        flip = '0;
        pins = dwec_pkg::t_pins'($urandom_range(0, 15));
        if (pick < 55) begin
            if ($urandom_range(0, 2) == 1) begin
                flip[dwec_pkg::PIN_RA] = 1'b1;
            end else if ($urandom_range(0, 1) == 1) begin
                flip[dwec_pkg::PIN_RB] = 1'b1;
            end
            if ($urandom_range(0, 2) == 1) begin
                flip[dwec_pkg::PIN_LA] = 1'b1;
            end else if ($urandom_range(0, 1) == 1) begin
                flip[dwec_pkg::PIN_LB] = 1'b1;
            end
            if (flip == '0) begin
                flip[$urandom_range(0, 3)] = 1'b1;
            end
            req  = dwec_pkg::REQ_SAMPLE;
            pins = sent_pins ^ flip;
        end else if (pick < 67) begin
            req = dwec_pkg::REQ_SAMPLE;
        end else if (pick < 71) begin
            req  = dwec_pkg::REQ_SAMPLE;
            pins = sent_pins;
        end else if (pick < 76) begin
            req = REQ_UNUSED;
        end else if (pick < 88) begin
            req = dwec_pkg::REQ_READ_RIGHT;
        end else begin
            req = dwec_pkg::REQ_READ_LEFT;
        end
    endtask

    initial begin
        dwec_pkg::t_req  req;
        dwec_pkg::t_pins pins;
        int              target;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_modes(dwec_pkg::MODE_AB_BOTH, dwec_pkg::MODE_A_BOTH);
        send_item(dwec_pkg::REQ_READ_RIGHT, 4'h0);
        send_item(dwec_pkg::REQ_READ_LEFT, 4'hF);
        send_item(dwec_pkg::REQ_SAMPLE, 4'h0);
        send_item(dwec_pkg::REQ_READ_RIGHT, 4'h0);
        send_item(dwec_pkg::REQ_SAMPLE, 4'hF);
        send_item(REQ_UNUSED, 4'h0);
        send_item(dwec_pkg::REQ_SAMPLE, 4'hF);
        send_item(dwec_pkg::REQ_READ_RIGHT, 4'h5);
        send_item(dwec_pkg::REQ_READ_RIGHT, 4'hA);
        send_item(dwec_pkg::REQ_READ_LEFT, 4'h0);
        send_item(dwec_pkg::REQ_SAMPLE, 4'h0);
        send_item(dwec_pkg::REQ_SAMPLE, 4'hA);
        send_item(dwec_pkg::REQ_SAMPLE, 4'h5);
        send_item(dwec_pkg::REQ_READ_RIGHT, 4'hF);
        send_item(dwec_pkg::REQ_READ_LEFT, 4'hF);
        send_item(REQ_UNUSED, 4'hF);
        settle();
        set_modes(dwec_pkg::MODE_A_RISE, dwec_pkg::MODE_AB_RISE);
        send_item(dwec_pkg::REQ_SAMPLE, 4'hF);
        send_item(dwec_pkg::REQ_SAMPLE, 4'h0);
        send_item(dwec_pkg::REQ_SAMPLE, 4'h3);
        send_item(dwec_pkg::REQ_READ_RIGHT, 4'h0);
        send_item(dwec_pkg::REQ_READ_LEFT, 4'h0);

        for (int phase = 0; phase < 6; phase++) begin
            settle();
            set_modes(right_modes[phase], left_modes[phase]);
            sender_idle_pct <= send_idle[phase];
            recv_stall_pct  <= recv_stall[phase];
            target = n_items + PHASE_ITEMS;
            while (n_items < target) begin
                next_random(req, pins);
                send_item(req, pins);
            end
        end
        settle();

        $display("Covered %0d items: %0d pin samples and %0d count reads checked.",
                 n_items, sb.n_samples, sb.n_reads);
        $display("Ran %0d edge mode settings under four idling patterns; %0d mismatches.",
                 n_settings, sb.n_mismatches);
        if (sb.n_mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
